// ===== rtl/core/mma_pkg.sv =====
// shared types and constants for the matrix multiply-accumulate block
package mma_pkg;

    localparam int MAX_DIM   = 16;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = 5;
    localparam int AB_W      = 16;
    localparam int C_W       = 40;
    localparam int PROD_W    = 2 * AB_W;
    localparam int CMD_W     = 3;
    localparam int FIELD_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD_A = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_C = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MAC    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_C = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

    localparam logic signed [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};
    localparam logic signed [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};

    // token handed from cell to cell along the chain
    typedef struct packed {
        logic                     vld;
        logic                     last;
        logic signed [C_W-1:0]    acc;
        logic                     ovf;
    } mma_tok_t;

endpackage

// ===== rtl/core/matrix_multiply_accumulate.sv =====
// matrix multiply-accumulate top level: stores, sequencer and chain of MAC cells
//
//  channel  ports                    fields (low bit up)
//  cfg      cfg_valid/ready          cfg_index, cfg_data
//  in       s_axis_t*                tdata: cmd, row, col, value
//  out      m_axis_t*                tdata: out_row, out_col, out_value; tuser: is_done, saturated
//
// loads are taken back to back; a read holds off the next input until its result is registered
// a multiply feeds rows*cols C elements into a chain of MAX_DIM cells at one per cycle,
// then drains the chain in ST_DRAIN and puts a done item on the output in ST_DONE
// c clears after reset with one entry per cycle, all MAX_DIM*MAX_DIM entries
// input stalls during the clear, a multiply, a read in flight or a full output register
module matrix_multiply_accumulate (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mma_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mma_pkg::DIM_W-1:0]         cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [55:0]                       s_axis_tdata,  // cmd, row, col, value
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [47:0]                       m_axis_tdata,  // out_row, out_col, out_value
    output logic [1:0]                        m_axis_tuser   // is_done, saturated
);
    import mma_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int CNT_W = $clog2(MAX_DIM + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FEED  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // input fields
    logic [CMD_W-1:0]   in_cmd;
    logic [FIELD_W-1:0] in_row, in_col;
    logic [C_W-1:0]     in_value;
    logic               in_inside;
    logic [ADDR_W-1:0]  in_addr;
    assign in_cmd   = s_axis_tdata[2:0];
    assign in_row   = s_axis_tdata[6:3];
    assign in_col   = s_axis_tdata[10:7];
    assign in_value = s_axis_tdata[50:11];
    assign in_inside = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    assign in_addr  = {in_row[IDX_W-1:0], in_col[IDX_W-1:0]};

    logic [2:0] state_reg, state_next;
    logic [DIM_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [CNT_W-1:0] nr, ni, nc;
    logic [ADDR_W:0] clr_reg;
    logic [IDX_W:0] fi_reg, fk_reg;
    logic [CNT_W:0] drain_reg;
    logic ovf_reg;

    // accumulator memory
    logic signed [C_W-1:0]  c_mem [DEPTH];

    // output register
    logic                  ov_reg;
    logic [FIELD_W-1:0]    or_reg, oc_reg;
    logic [C_W-1:0]        oval_reg;
    logic                  odone_reg, osat_reg;
    logic                  rd_pend_reg, rd_in_reg;

    logic in_xfer, out_free;
    assign out_free = !ov_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !rd_pend_reg && out_free;
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    function automatic logic [CNT_W-1:0] eff(input logic [DIM_W-1:0] d);
        eff = (32'(d) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(d);
    endfunction
    assign nr = eff(rows_reg);
    assign ni = eff(inner_reg);
    assign nc = eff(cols_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= DIM_W'(16);
            inner_reg <= DIM_W'(16);
            cols_reg  <= DIM_W'(16);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROWS:  rows_reg  <= cfg_data;
                REG_INNER: inner_reg <= cfg_data;
                REG_COLS:  cols_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    // feed stage: read C and injects token; the C element address travels alongside
    logic feeding;
    logic [ADDR_W-1:0] feed_addr;
    assign feeding = (state_reg == ST_FEED);
    assign feed_addr = {fi_reg[IDX_W-1:0], fk_reg[IDX_W-1:0]};

    logic                   f1_vld_reg;
    logic [ADDR_W-1:0]      f1_addr_reg;
    logic signed [C_W-1:0]  f1_c_reg;
    logic [ADDR_W-1:0]      rd_addr;
    assign rd_addr = feeding ? feed_addr : in_addr;

    always_ff @(posedge aclk) begin
        f1_c_reg    <= c_mem[rd_addr];
        f1_addr_reg <= feed_addr;
        if (!aresetn) f1_vld_reg <= 1'b0;
        else          f1_vld_reg <= feeding;
    end

    // chain: cell j holds column j of A and row j of B, and sees the token once it has passed the cells before it
    logic [ADDR_W-1:0]      addr_line [MAX_DIM+1];
    mma_tok_t               tok [MAX_DIM+1];
    logic                   en_line [MAX_DIM];

    assign tok[0].vld  = f1_vld_reg;
    assign tok[0].last = 1'b0;
    assign tok[0].acc  = f1_c_reg;
    assign tok[0].ovf  = 1'b0;
    assign addr_line[0] = f1_addr_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_DIM; g++) begin : g_chain
            logic [ADDR_W-1:0] addr_reg;
            logic [ADDR_W-1:0] ahead;
            logic              a_we, b_we;
            logic [IDX_W-1:0]  wr_idx;
            // address this cell works on in the next cycle
            if (g == 0) begin : g_head
                assign ahead = feed_addr;
            end else begin : g_body
                assign ahead = addr_line[g-1];
            end
            assign a_we = in_xfer && in_inside && in_cmd == CMD_LOAD_A &&
                          in_col[IDX_W-1:0] == IDX_W'(g);
            assign b_we = in_xfer && in_inside && in_cmd == CMD_LOAD_B &&
                          in_row[IDX_W-1:0] == IDX_W'(g);
            assign wr_idx = a_we ? in_row[IDX_W-1:0] : in_col[IDX_W-1:0];
            assign en_line[g] = tok[g].vld && (g < 32'(ni));
            mma_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .a_we    (a_we),
                .b_we    (b_we),
                .wr_idx  (wr_idx),
                .wr_data (in_value[AB_W-1:0]),
                .rd_row  (ahead[ADDR_W-1:IDX_W]),
                .rd_col  (ahead[IDX_W-1:0]),
                .en_in   (en_line[g]),
                .tok_in  (tok[g]),
                .tok_out (tok[g+1])
            );
            always_ff @(posedge aclk) addr_reg <= addr_line[g];
            assign addr_line[g+1] = addr_reg;
        end
    endgenerate

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == (ADDR_W+1)'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_xfer && in_cmd == CMD_MAC)
                          state_next = (nr == 0 || nc == 0) ? ST_DRAIN : ST_FEED;
            ST_FEED:  if (32'(fi_reg) == 32'(nr) - 1 && 32'(fk_reg) == 32'(nc) - 1)
                          state_next = ST_DRAIN;
            ST_DRAIN: if (32'(drain_reg) == MAX_DIM + 1) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            fi_reg    <= '0;
            fk_reg    <= '0;
            drain_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_IDLE && in_xfer && in_cmd == CMD_MAC) begin
                ovf_reg   <= 1'b0;
                fi_reg    <= '0;
                fk_reg    <= '0;
                drain_reg <= '0;
            end
            if (feeding) begin
                if (32'(fk_reg) == 32'(nc) - 1) begin
                    fk_reg <= '0;
                    fi_reg <= fi_reg + 1'b1;
                end else begin
                    fk_reg <= fk_reg + 1'b1;
                end
            end
            if (state_reg == ST_DRAIN) drain_reg <= drain_reg + 1'b1;
            if (tok[MAX_DIM].vld && tok[MAX_DIM].ovf) ovf_reg <= 1'b1;
        end
    end

    // C store writes: clear sweep, chain write-back and loads
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR)
            c_mem[clr_reg[ADDR_W-1:0]] <= '0;
        else if (tok[MAX_DIM].vld)
            c_mem[addr_line[MAX_DIM]] <= tok[MAX_DIM].acc;
        else if (in_xfer && in_inside && in_cmd == CMD_LOAD_C)
            c_mem[in_addr] <= in_value;
    end

    // read tracking: data comes out of the C port in the next cycle
    logic [FIELD_W-1:0] rd_row_reg, rd_col_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) rd_pend_reg <= 1'b0;
        else          rd_pend_reg <= in_xfer && in_cmd == CMD_READ_C;
        rd_in_reg  <= in_inside;
        rd_row_reg <= in_row;
        rd_col_reg <= in_col;
    end

    // output register; a read in flight blocks the next input
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg   <= 1'b0;
        end else begin
            if (rd_pend_reg) begin
                ov_reg    <= 1'b1;
                or_reg    <= rd_row_reg;
                oc_reg    <= rd_col_reg;
                oval_reg  <= rd_in_reg ? f1_c_reg : '0;
                odone_reg <= 1'b0;
                osat_reg  <= ovf_reg;
            end else if (state_reg == ST_DONE && out_free) begin
                ov_reg    <= 1'b1;
                or_reg    <= '0;
                oc_reg    <= '0;
                oval_reg  <= '0;
                odone_reg <= 1'b1;
                osat_reg  <= ovf_reg;
            end else if (m_axis_tready) begin
                ov_reg    <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {oval_reg, oc_reg, or_reg};
    assign m_axis_tuser  = {osat_reg, odone_reg};

`ifndef ASSERT_OFF
    // a read result never lands while the output register still holds an untaken item
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> !($past(ov_reg) && !$past(m_axis_tready)) || !$past(ov_reg))
        else $error("read result overwrote pending output");
    // no input accepted while the end of the chain still carries a token
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |-> !tok[MAX_DIM].vld)
        else $error("input accepted during multiply");
    // clear sweep ends before any input
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_axis_tready)
        else $error("ready during clear");
`endif

endmodule

// ===== rtl/core/mma_cell.sv =====
// one multiply-accumulate cell: adds its stored a*b product to the passing token
module mma_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            a_we,
    input  logic                            b_we,
    input  logic [mma_pkg::IDX_W-1:0]       wr_idx,
    input  logic signed [mma_pkg::AB_W-1:0] wr_data,
    input  logic [mma_pkg::IDX_W-1:0]       rd_row,
    input  logic [mma_pkg::IDX_W-1:0]       rd_col,
    input  logic                            en_in,
    input  mma_pkg::mma_tok_t               tok_in,
    output mma_pkg::mma_tok_t               tok_out
);
    import mma_pkg::*;

    logic signed [AB_W-1:0]   a_col [MAX_DIM];
    logic signed [AB_W-1:0]   b_row [MAX_DIM];
    logic signed [AB_W-1:0]   a_op_reg;
    logic signed [AB_W-1:0]   b_op_reg;
    logic signed [PROD_W-1:0] prod;
    logic signed [C_W:0]      sum;
    mma_tok_t                 tok_next;
    mma_tok_t                 tok_reg;

    // operand stores: this cell's column of A and row of B, read ahead of the token that uses them
    always_ff @(posedge aclk) begin
        if (a_we) a_col[wr_idx] <= wr_data;
        if (b_we) b_row[wr_idx] <= wr_data;
        a_op_reg <= a_col[rd_row];
        b_op_reg <= b_row[rd_col];
    end

    // product and saturating add
    always_comb begin
        prod     = a_op_reg * b_op_reg;
        sum      = {tok_in.acc[C_W-1], tok_in.acc} + {{(C_W+1-PROD_W){prod[PROD_W-1]}}, prod};
        tok_next = tok_in;
        if (en_in) begin
            if (sum[C_W] != sum[C_W-1]) begin
                tok_next.acc = sum[C_W] ? C_MIN : C_MAX;
                tok_next.ovf = 1'b1;
            end else begin
                tok_next.acc = sum[C_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
        end else begin
            tok_reg.vld <= tok_in.vld;
        end
        tok_reg.last <= tok_in.last;
        tok_reg.acc  <= tok_next.acc;
        tok_reg.ovf  <= tok_next.ovf;
    end

    assign tok_out = tok_reg;

endmodule
